@@ sv/utf8_lossy_repair_assert.svh @@
// Assertion macros shared by the checker of the UTF-8 repair block.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef UTF8_LOSSY_REPAIR_ASSERT_SVH
`define UTF8_LOSSY_REPAIR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ULR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ULR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/ulr_pkg.sv @@
// Package of the UTF-8 repair block: byte codes, job type, classifier functions.
// No dependencies.
package ulr_pkg;

  localparam int unsigned MaxOut   = 6;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [7:0] RepByte0 = 8'hEF;
  localparam logic [7:0] RepByte1 = 8'hBF;
  localparam logic [7:0] RepByte2 = 8'hBD;

  localparam logic [7:0] ContLo   = 8'h80;
  localparam logic [7:0] ContHi   = 8'hBF;
  localparam logic [7:0] Lead2Lo  = 8'hC2;
  localparam logic [7:0] Lead2Hi  = 8'hDF;
  localparam logic [7:0] Lead3Lo  = 8'hE0;
  localparam logic [7:0] Lead3Hi  = 8'hEF;
  localparam logic [7:0] Lead4Lo  = 8'hF0;
  localparam logic [7:0] Lead4Hi  = 8'hF4;
  localparam logic [7:0] LeadSurr = 8'hED;
  localparam logic [7:0] LimA0    = 8'hA0;
  localparam logic [7:0] Lim90    = 8'h90;
  localparam logic [7:0] Lim8F    = 8'h8F;

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_class_e;

  // One queue entry: all result bytes caused by one input byte.
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [2:0]             cnt;
    logic                   eob;
  } ulr_job_t;

  function automatic lead_class_e classify_lead(input logic [7:0] b);
    lead_class_e c;
    if (b < ContLo)                       c = LEAD_ASCII;
    else if (b >= Lead2Lo && b <= Lead2Hi) c = LEAD_TWO;
    else if (b >= Lead3Lo && b <= Lead3Hi) c = LEAD_THREE;
    else if (b >= Lead4Lo && b <= Lead4Hi) c = LEAD_FOUR;
    else                                  c = LEAD_BAD;
    return c;
  endfunction

  function automatic logic cont_ok(input logic [7:0] b, input logic second,
                                   input logic [7:0] lead);
    logic ok;
    ok = (b >= ContLo) && (b <= ContHi);
    if (second) begin
      if (lead == Lead3Lo && b < LimA0)   ok = 1'b0;
      if (lead == LeadSurr && b >= LimA0) ok = 1'b0;
      if (lead == Lead4Lo && b < Lim90)   ok = 1'b0;
      if (lead == Lead4Hi && b > Lim8F)   ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

@@ sv/utf8_lossy_repair.sv @@
// Top level of the streaming UTF-8 repair block.
// Depends on ulr_pkg, ulr_front, ulr_queue and ulr_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one raw byte per
//   transaction plus end_of_buffer_i on the final byte of a buffer.
//   Output channel (out_valid_o / out_stall_i) carries one repaired byte
//   per transaction; run_last_o marks the last byte caused by one input
//   byte, buffer_last_o the last byte of a buffer.
//   Each input byte causes 0 to 6 output bytes. Ill-formed subparts come
//   out as EF BF BD; a multi-byte sequence is held until complete.
// Path: an accepted input byte is written into the job queue, and its first
//   output byte then enters the output register.
// Throughput: one input byte per cycle while the four-entry job queue has
//   room; the output register drains one byte per cycle while out_stall_i
//   is low, and the back part holds each job until all its results are out.
// Reset: clears the prefix count, the queue and the output valid; no
//   prefix is held afterwards.
// Stall: when out_stall_i is high the output transaction holds; the queue
//   keeps absorbing input until full, then in_stall_o rises.
module utf8_lossy_repair import ulr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_buffer_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       buffer_last_o
);

  ulr_job_t job, head;
  logic     push, pop, full, empty, accept;

  // Stall only on a full queue; this is a registered condition.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;

  ulr_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i        (accept),
    .in_byte_i,
    .end_of_buffer_i,
    .push_o          (push),
    .job_o           (job)
  );

  ulr_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_job_i (job),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty)
  );

  ulr_back u_back (
    .clk_i,
    .rst_ni,
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o,
    .out_stall_i,
    .out_byte_o,
    .run_last_o,
    .buffer_last_o
  );

endmodule

@@ sv/ulr_front.sv @@
// Front part: holds the prefix state, classifies each byte and builds its job.
// Depends on ulr_pkg.
module ulr_front import ulr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_buffer_i,
  output logic       push_o,
  output ulr_job_t   job_o
);

  logic [2:0][7:0] store_q, store_d;
  logic [1:0]      count_q, count_d;
  logic [2:0]      len_q, len_d;

  lead_class_e     cls;
  logic            ok;
  logic            lead_phase;
  logic [2:0]      off;
  logic [2:0]      n;

  assign cls = classify_lead(in_byte_i);
  assign ok  = cont_ok(in_byte_i, count_q == 2'd1, store_q[0]);

  always_comb begin
    store_d    = store_q;
    count_d    = count_q;
    len_d      = len_q;
    job_o      = '0;
    n          = 3'd0;
    off        = 3'd0;
    lead_phase = 1'b0;

    if (count_q == 2'd0) begin
      lead_phase = 1'b1;
    end else if (ok) begin
      if ({1'b0, count_q} + 3'd1 >= len_q) begin
        // complete: emit the held prefix followed by this byte
        job_o.bytes[0] = store_q[0];
        case (count_q)
          2'd1: begin
            job_o.bytes[1] = in_byte_i;
            n = 3'd2;
          end
          2'd2: begin
            job_o.bytes[1] = store_q[1];
            job_o.bytes[2] = in_byte_i;
            n = 3'd3;
          end
          default: begin
            job_o.bytes[1] = store_q[1];
            job_o.bytes[2] = store_q[2];
            job_o.bytes[3] = in_byte_i;
            n = 3'd4;
          end
        endcase
        count_d = 2'd0;
        len_d   = 3'd0;
      end else begin
        store_d[count_q] = in_byte_i;
        count_d          = count_q + 2'd1;
      end
    end else begin
      // rejected continuation: replace the prefix, retry the byte as a lead
      job_o.bytes[0] = RepByte0;
      job_o.bytes[1] = RepByte1;
      job_o.bytes[2] = RepByte2;
      n          = 3'd3;
      off        = 3'd3;
      count_d    = 2'd0;
      len_d      = 3'd0;
      lead_phase = 1'b1;
    end

    if (lead_phase) begin
      case (cls)
        LEAD_ASCII: begin
          job_o.bytes[off] = in_byte_i;
          n = off + 3'd1;
        end
        LEAD_BAD: begin
          job_o.bytes[off]        = RepByte0;
          job_o.bytes[off + 3'd1] = RepByte1;
          job_o.bytes[off + 3'd2] = RepByte2;
          n = off + 3'd3;
        end
        LEAD_TWO, LEAD_THREE, LEAD_FOUR: begin
          store_d[0] = in_byte_i;
          count_d    = 2'd1;
          len_d      = (cls == LEAD_TWO) ? 3'd2 : (cls == LEAD_THREE) ? 3'd3 : 3'd4;
        end
        default: begin
          n = off;
        end
      endcase
    end

    // flush a truncated prefix at the end of the buffer
    if (end_of_buffer_i && count_d != 2'd0) begin
      job_o.bytes[n]        = RepByte0;
      job_o.bytes[n + 3'd1] = RepByte1;
      job_o.bytes[n + 3'd2] = RepByte2;
      n       = n + 3'd3;
      count_d = 2'd0;
      len_d   = 3'd0;
    end

    job_o.cnt = n;
    job_o.eob = end_of_buffer_i;
  end

  assign push_o = accept_i && (n != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      len_q   <= 3'd0;
    end else if (accept_i) begin
      count_q <= count_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      store_q <= store_d;
    end
  end

endmodule

@@ sv/ulr_queue.sv @@
// Job queue between the front and back parts.
// Depends on ulr_pkg.
module ulr_queue import ulr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ulr_job_t push_job_i,
  output logic     full_o,
  input  logic     pop_i,
  output ulr_job_t head_o,
  output logic     empty_o
);

  ulr_job_t         entries_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entries_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entries_q[wr_q] <= push_job_i;
  end

endmodule

@@ sv/ulr_back.sv @@
// Back part: walks the head job byte by byte into the output register.
// Depends on ulr_pkg.
module ulr_back import ulr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ulr_job_t   head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       buffer_last_o
);

  logic [2:0] idx_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       run_last_q, buffer_last_q;
  logic       load, last;

  assign load  = !empty_i && (!valid_q || !out_stall_i);
  assign last  = (idx_q == head_i.cnt - 3'd1);
  assign pop_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 3'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= last ? 3'd0 : idx_q + 3'd1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q        <= head_i.bytes[idx_q];
      run_last_q    <= last;
      buffer_last_q <= last && head_i.eob;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = byte_q;
  assign run_last_o    = run_last_q;
  assign buffer_last_o = buffer_last_q;

endmodule

@@ sv/ulr_checker.sv @@
// Port-level checker for the UTF-8 repair block, bound to the top level.
// Depends on utf8_lossy_repair_assert.svh.
`include "utf8_lossy_repair_assert.svh"

module ulr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] in_byte_i,
  input logic       end_of_buffer_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       run_last_o,
  input logic       buffer_last_o
);

  // A stalled input transaction holds.
  `ULR_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i && $stable(in_byte_i) && $stable(end_of_buffer_i))

  // A stalled output transaction holds.
  `ULR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o) && $stable(run_last_o) && $stable(buffer_last_o))

  // The end of a buffer always closes a run.
  `ULR_ASSERT_IMPL(a_buf_last_run, out_valid_o && buffer_last_o, run_last_o)

  // A multi-byte lead is never the last byte of its run.
  `ULR_ASSERT_IMPL(a_lead_not_last, out_valid_o && out_byte_o >= 8'hC0, !run_last_o)

  // Never-valid bytes never leave the block.
  `ULR_ASSERT_IMPL(a_no_bad_byte, out_valid_o, out_byte_o != 8'hC0 && out_byte_o != 8'hC1 && out_byte_o < 8'hF5)

endmodule

bind utf8_lossy_repair ulr_checker u_chk (.*);

@@ verif/testbench.sv @@
// Testbench of utf8_lossy_repair: a directed byte table, then random UTF-8 streams.
// Each repaired byte is checked against a typed row or a behavioral repair predictor.
// Depends on ulr_pkg and utf8_lossy_repair.
module testbench;
  import ulr_pkg::*;

  localparam int unsigned RandomItems = 245;  // random bytes after the directed table, at least
  localparam int unsigned IdleLimit   = 1000; // cycles without any transaction
  localparam int unsigned LongHold    = 80;   // receiver hold-off, far beyond the queue depth
  localparam int unsigned DrainCycles = 20;   // quiet cycles after the last expected byte
  localparam int unsigned MaxReports  = 10;
  localparam logic [23:0] Rep         = {RepByte0, RepByte1, RepByte2};

  // One output transaction as the block should present it.
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       buffer_last;
  } out_beat_t;

  // One stimulus row. Where typed is set, out_bytes holds the n_out expected bytes,
  // first byte in the top bits; otherwise the predictor decides.
  typedef struct packed {
    logic [7:0]  data;
    logic        eob;
    logic        typed;
    logic [2:0]  n_out;
    logic [47:0] out_bytes;
  } dir_row_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte   = '0;
  logic       in_eob    = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;
  logic       buffer_last;

  // Predictor state: held prefix bytes and the length of the sequence they open.
  logic [7:0]  prefix_buf [3];
  int unsigned prefix_len = 0;
  int unsigned seq_len    = 0;
  logic [7:0]  step_out [$];   // bytes caused by the byte being predicted
  out_beat_t   due_beats [$];  // repaired bytes still to come out, oldest first
  logic [7:0]  char_q [$];     // bytes of the random character being sent

  // Shape of the idling, steered by the stimulus process.
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  bit hold_req = 1'b0;

  int unsigned bytes_in   = 0;
  int unsigned buffers    = 0;
  int unsigned bytes_out  = 0;
  int unsigned holds      = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  utf8_lossy_repair uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_byte_i      (in_byte),
    .end_of_buffer_i(in_eob),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_byte_o     (out_byte),
    .run_last_o     (run_last),
    .buffer_last_o  (buffer_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic emit_replacement();
    step_out.push_back(RepByte0);
    step_out.push_back(RepByte1);
    step_out.push_back(RepByte2);
  endtask

  // Take a byte as the start of a new character: pass ASCII, open a prefix for a
  // valid lead, replace anything else.
  task automatic open_lead(input logic [7:0] b);
    int unsigned len;
    len = 0;
    if (b >= Lead2Lo && b <= Lead2Hi) len = 2;
    else if (b >= Lead3Lo && b <= Lead3Hi) len = 3;
    else if (b >= Lead4Lo && b <= Lead4Hi) len = 4;
    if (b < ContLo) begin
      step_out.push_back(b);
    end else if (len != 0) begin
      prefix_buf[0] = b;
      prefix_len    = 1;
      seq_len       = len;
    end else begin
      emit_replacement();
    end
  endtask

  // Advance the predictor by one input byte; the bytes it causes land in step_out.
  task automatic repair_step(input logic [7:0] b, input logic eob);
    logic fits;
    step_out.delete();
    fits = (b >= ContLo) && (b <= ContHi);
    // The second byte of some leads has a narrower range: no overlongs after E0
    // and F0, no surrogates after ED, nothing past U+10FFFF after F4.
    if (prefix_len == 1) begin
      if (prefix_buf[0] == Lead3Lo && b < LimA0) fits = 1'b0;
      if (prefix_buf[0] == LeadSurr && b >= LimA0) fits = 1'b0;
      if (prefix_buf[0] == Lead4Lo && b < Lim90) fits = 1'b0;
      if (prefix_buf[0] == Lead4Hi && b > Lim8F) fits = 1'b0;
    end
    if (prefix_len == 0) begin
      open_lead(b);
    end else if (fits) begin
      if (prefix_len + 1 >= seq_len) begin
        for (int i = 0; i < prefix_len; i++) step_out.push_back(prefix_buf[i]);
        step_out.push_back(b);
        prefix_len = 0;
      end else begin
        prefix_buf[prefix_len] = b;
        prefix_len++;
      end
    end else begin
      // A rejected continuation closes the prefix, then starts over as a lead.
      emit_replacement();
      prefix_len = 0;
      open_lead(b);
    end
    // End of buffer flushes a truncated prefix as one replacement.
    if (eob && prefix_len != 0) begin
      emit_replacement();
      prefix_len = 0;
    end
  endtask

  task automatic book_results(input logic eob);
    out_beat_t beat;
    for (int k = 0; k < step_out.size(); k++) begin
      beat.data        = step_out[k];
      beat.run_last    = (k == step_out.size() - 1);
      beat.buffer_last = beat.run_last && eob;
      due_beats.push_back(beat);
    end
  endtask

  // Offer one byte after a random gap, hold it until accepted, then book what it causes.
  task automatic send_byte(input dir_row_t row);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(9, 0);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= row.data;
    in_eob   <= row.eob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    repair_step(row.data, row.eob);
    if (row.typed) begin
      step_out.delete();
      for (int k = 0; k < row.n_out; k++) step_out.push_back(row.out_bytes[47 - 8 * k -: 8]);
    end
    book_results(row.eob);
    bytes_in++;
    if (row.eob) buffers++;
    @(negedge clk);
  endtask

  // Build one well-formed character of len bytes with random content. The leads E0
  // and ED, with a narrow second byte, get extra weight so their limits are hit often.
  task automatic make_char(input int unsigned len);
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] nb;
    char_q.delete();
    case (len)
      1: lead = 8'($urandom_range(8'h7F, 8'h00));
      2: lead = 8'($urandom_range(Lead2Hi, Lead2Lo));
      3: begin
        if ($urandom_range(3, 0) == 0) lead = $urandom_range(1, 0) ? Lead3Lo : LeadSurr;
        else lead = 8'($urandom_range(Lead3Hi, Lead3Lo));
      end
      default: lead = 8'($urandom_range(Lead4Hi, Lead4Lo));
    endcase
    char_q.push_back(lead);
    lo = ContLo;
    hi = ContHi;
    if (lead == Lead3Lo) lo = LimA0;
    if (lead == LeadSurr) hi = LimA0 - 8'd1;
    if (lead == Lead4Lo) lo = Lim90;
    if (lead == Lead4Hi) hi = Lim8F;
    for (int i = 1; i < len; i++) begin
      if (i == 1) nb = 8'($urandom_range(hi, lo));
      else nb = 8'($urandom_range(ContHi, ContLo));
      char_q.push_back(nb);
    end
  endtask

  // Stimulus: reset, directed table, random streams, drain, verdict.
  initial begin
    dir_row_t    dir_rows [25];
    dir_row_t    row;
    int unsigned sent;
    int unsigned kind;
    int unsigned pos;
    logic [7:0]  noise;
    dir_rows = '{
      '{8'h00, 1'b0, 1'b1, 3'd1, {8'h00, 40'h0}},  // lowest byte passes
      '{8'hFF, 1'b0, 1'b1, 3'd3, {Rep, 24'h0}},    // highest byte is never a lead
      '{8'h80, 1'b0, 1'b1, 3'd3, {Rep, 24'h0}},    // stray continuation
      '{8'hC2, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h80, 1'b0, 1'b0, 3'd0, 48'h0},           // smallest two-byte character
      '{8'hE0, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h9F, 1'b0, 1'b1, 3'd6, {Rep, Rep}},      // overlong three-byte, 9F bad as lead
      '{8'hE0, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'hA0, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'hBF, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'hED, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'hA0, 1'b0, 1'b1, 3'd6, {Rep, Rep}},      // surrogate
      '{8'hF0, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h8F, 1'b0, 1'b1, 3'd6, {Rep, Rep}},      // overlong four-byte
      '{8'hF4, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h8F, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'hBF, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'hBF, 1'b0, 1'b0, 3'd0, 48'h0},           // U+10FFFF, the top code point
      '{8'hE1, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h41, 1'b0, 1'b1, 3'd4, {Rep, 8'h41, 16'h0}},  // bad continuation, retaken as ASCII
      '{8'hF1, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h80, 1'b1, 1'b1, 3'd3, {Rep, 24'h0}},    // buffer ends inside a character
      '{8'hC3, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'hC3, 1'b1, 1'b1, 3'd6, {Rep, Rep}},      // reject, new lead, then flush
      '{8'h41, 1'b1, 1'b1, 3'd1, {8'h41, 40'h0}}   // one-byte buffer
    };
    sent = 0;

    // Hold reset, release it away from the rising edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_byte(dir_rows[i]);

    // Random part: mostly well-formed characters, the rest truncated characters,
    // corrupted characters and raw noise. Buffer ends fall anywhere.
    while (sent < RandomItems) begin
      kind = $urandom_range(9, 0);
      make_char($urandom_range(4, 1));
      if (kind == 7 && char_q.size() > 1) begin
        void'(char_q.pop_back());
      end else if (kind == 8 && char_q.size() > 1) begin
        pos         = $urandom_range(char_q.size() - 1, 1);
        noise       = 8'($urandom_range(255, 0));
        char_q[pos] = noise;
      end else if (kind == 9) begin
        noise = 8'($urandom_range(255, 0));
        char_q.delete();
        char_q.push_back(noise);
      end
      foreach (char_q[i]) begin
        // Both sides run flat out for a stretch; later the sender keeps pushing
        // while the receiver holds off, so the queue fills and stalls the input.
        tx_burst = (sent >= 60 && sent < 100) || (sent >= 140 && sent < 180);
        rx_burst = (sent >= 60 && sent < 100);
        if (sent == 140) hold_req = 1'b1;
        row       = '0;
        row.data  = char_q[i];
        row.eob   = ($urandom_range(11, 0) == 0);
        send_byte(row);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every booked byte, then watch for strays.
    while (due_beats.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d bytes over %0d buffer ends, checked %0d repaired bytes.",
             bytes_in, buffers, bytes_out);
    $display("Receiver long hold-offs: %0d, mismatches: %0d.", holds, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver: stall for a random number of cycles per transaction (none during a
  // burst), or for the long hold-off when the stimulus asks for one.
  initial begin
    int unsigned gap;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap      = LongHold;
        holds++;
      end else begin
        gap = rx_burst ? 0 : $urandom_range(9, 0);
      end
      repeat (gap) begin
        out_stall <= 1'b1;
        @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Check each accepted output transaction against the oldest booked byte.
  always @(posedge clk) begin : check_out
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      bytes_out++;
      if (due_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected output byte %h run_last %b buffer_last %b",
                   $time, out_byte, run_last, buffer_last);
      end else begin
        want = due_beats.pop_front();
        if (want.data !== out_byte || want.run_last !== run_last ||
            want.buffer_last !== buffer_last) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: expected byte %h run_last %b buffer_last %b, got %h %b %b",
                     $time, want.data, want.run_last, want.buffer_last,
                     out_byte, run_last, buffer_last);
        end
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Watchdog: no transaction for %0d cycles, %0d bytes still due.",
               IdleLimit, due_beats.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
